// ----- design/abst_pkg.sv -----
`default_nettype none

package abst_pkg;

    localparam int CFG_W       = 9;
    localparam int KEY_W       = 32;
    localparam int STAT_W      = 3;
    localparam int SLOT_OUT_W  = 8;
    localparam int DEF_MAX_SLOTS = 256;
    localparam logic [CFG_W-1:0] LIMIT_RESET = 9'd256;

    typedef logic [STAT_W-1:0] t_status;

    localparam t_status STAT_INSERTED  = 3'd0;
    localparam t_status STAT_DUPLICATE = 3'd1;
    localparam t_status STAT_FULL      = 3'd2;
    localparam t_status STAT_FOUND     = 3'd3;
    localparam t_status STAT_NOT_FOUND = 3'd4;
    localparam t_status STAT_EMPTY     = 3'd5;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    typedef struct packed {
        t_status                 status;
        logic [SLOT_OUT_W-1:0]   slot;
    } t_result;

endpackage

`default_nettype wire

// ----- design/abst_ram.sv -----
`default_nettype none

module abst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- design/abst_walk.sv -----
`default_nettype none

module abst_walk
    import abst_pkg::*;
#(
    parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [CFG_W-1:0]   i_limit,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_action,
    input  wire logic [KEY_W-1:0]   i_key,
    output logic                    o_res_valid,
    input  wire logic               i_res_ready,
    output t_result                 o_res
);

    localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW    = (CFG_W > IDX_W + 2) ? CFG_W : IDX_W + 2;
    localparam int ENT_W = KEY_W + 1;
    localparam logic [CW-1:0] MAX_CW = CW'(MAX_SLOTS);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_WALK  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_clr, n_clr;
    logic [IDX_W-1:0] r_node, n_node;
    logic             r_act, n_act;
    logic [KEY_W-1:0] r_key, n_key;

    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [ENT_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
    logic [ENT_W-1:0] rdata;

    logic [CW-1:0]    lim_ext, lim;
    logic [CW-1:0]    node_ext, child;
    logic             ent_valid;
    logic [KEY_W-1:0] here;
    logic             key_lt;
    logic             done;
    logic             do_write;
    t_result          res;
    logic             in_acc;

    abst_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        lim_ext   = CW'(i_limit);
        lim       = (lim_ext > MAX_CW) ? MAX_CW : lim_ext;
        node_ext  = CW'(r_node);
        ent_valid = rdata[KEY_W];
        here      = rdata[KEY_W-1:0];
        key_lt    = $signed(r_key) < $signed(here);
        child     = (node_ext << 1) + (key_lt ? CW'(1) : CW'(2));
    end

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_node   = r_node;
        n_act    = r_act;
        n_key    = r_key;
        done     = 1'b0;
        do_write = 1'b0;
        res      = '{status: STAT_EMPTY, slot: '0};
        raddr    = r_node;
        in_acc   = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + IDX_W'(1);
                if (CW'(r_clr) == MAX_CW - CW'(1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                raddr  = '0;
                in_acc = i_in_valid;
                if (i_in_valid) begin
                    n_act   = i_action;
                    n_key   = i_key;
                    n_node  = '0;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (lim == '0) begin
                    done = 1'b1;
                    res.status = (r_act == ACT_SEARCH) ? STAT_EMPTY : STAT_FULL;
                end else if (!ent_valid) begin
                    done = 1'b1;
                    if (r_act == ACT_SEARCH) begin
                        res.status = (r_node == '0) ? STAT_EMPTY : STAT_NOT_FOUND;
                    end else begin
                        res.status = STAT_INSERTED;
                        res.slot   = node_ext[SLOT_OUT_W-1:0];
                        do_write   = 1'b1;
                    end
                end else if (r_key == here) begin
                    done = 1'b1;
                    res.status = (r_act == ACT_SEARCH) ? STAT_FOUND : STAT_DUPLICATE;
                    res.slot   = node_ext[SLOT_OUT_W-1:0];
                end else if (child >= lim) begin
                    done = 1'b1;
                    res.status = (r_act == ACT_SEARCH) ? STAT_NOT_FOUND : STAT_FULL;
                end else begin
                    raddr  = child[IDX_W-1:0];
                    n_node = child[IDX_W-1:0];
                end
                if (done && i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_clr   = '0;
            end
        endcase
    end

    always_comb begin
        if (r_state == S_CLEAR) begin
            we    = 1'b1;
            waddr = r_clr;
            wdata = '0;
        end else begin
            we    = do_write && i_res_ready;
            waddr = r_node;
            wdata = {1'b1, r_key};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
        r_node <= n_node;
        r_act  <= n_act;
        r_key  <= n_key;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = done;
    assign o_res       = res;

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !we)
        else $error("store written while idle");

    a_res_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (r_state == S_WALK))
        else $error("result outside of walk");

    a_acc_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_WALK) && (r_node == '0))
        else $error("accepted transaction did not start at root");

    a_insert_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && i_res_ready && o_res.status == STAT_INSERTED) |-> we)
        else $error("insert reported without store write");

endmodule

`default_nettype wire

// ----- design/array_bst_insert_search.sv -----
// The walk visits L levels from the root, one store read per level, with L from
// 1 to floor(log2 MAX_SLOTS) + 1 (9 for 256 slots).
// A new transaction is accepted only in idle, once the previous walk has finished.
// The result register lets a new transaction be accepted while the last result waits.
// Reset (i_rst_n low, synchronous): limit returns to 256, then a clearing pass over
// all MAX_SLOTS entries zeroes the valid bits; o_s_axis_tready stays low during that pass.
`default_nettype none

module array_bst_insert_search
    import abst_pkg::*;
#(
    parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_W-1:0]      i_cfg_data,     // slot_limit
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [KEY_W-1:0]      i_s_axis_tdata, // key
    input  wire logic [0:0]            i_s_axis_tuser, // action
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic [SLOT_OUT_W-1:0]      o_m_axis_tdata, // slot_index
    output logic [STAT_W-1:0]          o_m_axis_tuser  // status
);

    logic [CFG_W-1:0] r_limit;
    logic             r_out_valid;
    t_result          r_out;
    logic             res_valid;
    logic             res_ready;
    t_result          res;

    assign o_cfg_ready = 1'b1;
    assign res_ready   = !r_out_valid || i_m_axis_tready;

    abst_walk #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_limit     (r_limit),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_action    (i_s_axis_tuser[0]),
        .i_key       (i_s_axis_tdata),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (res_ready) begin
                r_out_valid <= res_valid;
            end
        end
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out.slot;
    assign o_m_axis_tuser  = r_out.status;

endmodule

`default_nettype wire

// ----- tb/array_bst_checker.sv -----
`timescale 1ns / 1ps

module array_bst_checker
    import abst_pkg::*;
#(
    parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic                  i_cfg_ready,
    input  wire logic [CFG_W-1:0]      i_cfg_data,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_ready,
    input  wire logic [KEY_W-1:0]      i_in_key,
    input  wire logic                  i_in_action,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_ready,
    input  wire logic [SLOT_OUT_W-1:0] i_out_slot,
    input  wire logic [STAT_W-1:0]     i_out_status,
    output int                         o_pending,
    output int                         o_errors
);

    logic [KEY_W-1:0] tree_key   [MAX_SLOTS];
    logic             tree_valid [MAX_SLOTS];
    logic [CFG_W-1:0] limit_q;
    t_result          answers_q [$];
    int               n_err = 0;

    // root-down walk; inserts update the shadow tree
    function automatic t_result walk_tree(input logic act, input logic [KEY_W-1:0] k);
        t_result r;
        int lim;
        int node;
        int child;
        bit done;
        logic [KEY_W-1:0] here;
        lim = (int'(limit_q) > MAX_SLOTS) ? MAX_SLOTS : int'(limit_q);
        r.status = STAT_EMPTY;
        r.slot = '0;
        if (lim == 0 || !tree_valid[0]) begin
            if (act == ACT_SEARCH) begin
                r.status = STAT_EMPTY;
            end else if (lim == 0) begin
                r.status = STAT_FULL;
            end else begin
                tree_key[0] = k;
                tree_valid[0] = 1'b1;
                r.status = STAT_INSERTED;
            end
            return r;
        end
        node = 0;
        done = 1'b0;
        while (!done) begin
            here = tree_key[node];
            if (k == here) begin
                r.status = (act == ACT_SEARCH) ? STAT_FOUND : STAT_DUPLICATE;
                r.slot = node[SLOT_OUT_W-1:0];
                done = 1'b1;
            end else begin
                child = ($signed(k) < $signed(here)) ? 2 * node + 1 : 2 * node + 2;
                if (child >= lim) begin
                    r.status = (act == ACT_SEARCH) ? STAT_NOT_FOUND : STAT_FULL;
                    done = 1'b1;
                end else if (!tree_valid[child]) begin
                    if (act == ACT_SEARCH) begin
                        r.status = STAT_NOT_FOUND;
                    end else begin
                        tree_key[child] = k;
                        tree_valid[child] = 1'b1;
                        r.status = STAT_INSERTED;
                        r.slot = child[SLOT_OUT_W-1:0];
                    end
                    done = 1'b1;
                end else begin
                    node = child;
                end
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_SLOTS; i++) tree_valid[i] = 1'b0;
            limit_q = LIMIT_RESET;
            answers_q.delete();
        end else begin
            // results first: none can belong to an item taken at this edge
            if (i_out_valid && i_out_ready) begin
                got.status = i_out_status;
                got.slot = i_out_slot;
                if (answers_q.size() == 0) begin
                    $display("%0t: unexpected result, status %0d slot %0d",
                             $time, got.status, got.slot);
                    n_err++;
                end else begin
                    want = answers_q.pop_front();
                    if (got.status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d actual %0d",
                                 $time, want.status, got.status);
                        n_err++;
                    end
                    if (got.slot !== want.slot) begin
                        $display("%0t: slot mismatch, expected %0d actual %0d",
                                 $time, want.slot, got.slot);
                        n_err++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) limit_q = i_cfg_data;
            if (i_in_valid && i_in_ready) answers_q.push_back(walk_tree(i_in_action, i_in_key));
        end
        o_pending <= answers_q.size();
        o_errors <= n_err;
    end

endmodule

// ----- tb/tb_array_bst_insert_search.sv -----
`timescale 1ns / 1ps

module tb_array_bst_insert_search
    import abst_pkg::*;
();

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [KEY_W-1:0]      s_tdata;
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [SLOT_OUT_W-1:0] m_tdata;
    logic [STAT_W-1:0]     m_tuser;
    int                    n_pending;
    int                    n_errors;

    bit                    no_idle = 1'b0;
    logic [KEY_W-1:0]      sent_keys [$];

    array_bst_insert_search i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    array_bst_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (s_tvalid),
        .i_in_ready   (s_tready),
        .i_in_key     (s_tdata),
        .i_in_action  (s_tuser[0]),
        .i_out_valid  (m_tvalid),
        .i_out_ready  (m_tready),
        .i_out_slot   (m_tdata),
        .i_out_status (m_tuser),
        .o_pending    (n_pending),
        .o_errors     (n_errors)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("tb_array_bst_insert_search: done, errors");
        $finish;
    end

    // result side: random stall after each transaction
    initial begin
        int stall;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        m_tready <= 1'b1;
        forever begin
            do @(posedge clk); while (!(m_tvalid && m_tready));
            stall = no_idle ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send(input logic act, input logic [KEY_W-1:0] k);
        int gap;
        if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= k;
        s_tuser <= act;
        sent_keys.push_back(k);
        do @(posedge clk); while (!s_tready);
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (n_pending != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_limit(input logic [CFG_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [KEY_W-1:0] small_key();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            default: return $urandom_range(0, 15) - 8;
        endcase
    endfunction

    task automatic random_item();
        int r;
        logic act;
        logic [KEY_W-1:0] k;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            act = ACT_INSERT;
            k = $urandom();
        end else if (r < 55) begin
            act = ACT_INSERT;
            k = small_key();
        end else if (r < 85 && sent_keys.size() > 0) begin
            act = ACT_SEARCH;
            k = sent_keys[$urandom_range(0, sent_keys.size() - 1)];
        end else begin
            act = ACT_SEARCH;
            k = (r < 92) ? $urandom() : small_key();
        end
        send(act, k);
    endtask

    initial begin
        logic [CFG_W-1:0] phase_limit [8];
        rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= ACT_INSERT;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        send(ACT_SEARCH, 32'h0000_0000);
        write_limit(9'd0);
        send(ACT_INSERT, 32'h7fff_ffff);
        send(ACT_SEARCH, 32'h0000_0000);
        write_limit(9'd1);
        send(ACT_INSERT, 32'h0000_0000);
        send(ACT_INSERT, 32'h0000_0005);
        send(ACT_SEARCH, 32'h0000_0005);
        send(ACT_INSERT, 32'h0000_0000);
        send(ACT_SEARCH, 32'h0000_0000);
        write_limit(9'd3);
        send(ACT_INSERT, 32'h8000_0000);
        send(ACT_INSERT, 32'h7fff_ffff);
        send(ACT_SEARCH, 32'h8000_0000);
        send(ACT_SEARCH, 32'hffff_ffff);
        send(ACT_INSERT, 32'hffff_ffff);
        write_limit(9'd511);
        send(ACT_INSERT, 32'hffff_ffff);
        send(ACT_SEARCH, 32'hffff_ffff);
        send(ACT_INSERT, 32'h7fff_fffe);
        send(ACT_INSERT, 32'h7fff_fffe);
        send(ACT_SEARCH, 32'h0000_3039);
        // lowered limit hides deeper keys
        write_limit(9'd2);
        send(ACT_SEARCH, 32'h7fff_ffff);
        send(ACT_SEARCH, 32'h8000_0000);
        write_limit(9'd256);
        send(ACT_SEARCH, 32'h7fff_ffff);
        send(ACT_INSERT, 32'h5555_5555);
        send(ACT_INSERT, 32'haaaa_aaaa);

        phase_limit = '{9'd256, 9'd15, 9'd511, 9'd2, 9'd300, 9'd64, 9'd0, 9'd256};
        phase_limit[6] = CFG_W'($urandom_range(1, 511));
        for (int p = 0; p < 8; p++) begin
            write_limit(phase_limit[p]);
            for (int n = 0; n < 82; n++) begin
                if (p == 0 && n == 40) drain();
                random_item();
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (n_errors == 0 && n_pending == 0) begin
            $display("tb_array_bst_insert_search: done, clean");
        end else begin
            $display("tb_array_bst_insert_search: done, errors");
        end
        $finish;
    end

endmodule
